// ===== hdl/brpm_pkg.sv =====
// ----------------------------------------------------------------------------
// brpm_pkg: shared types and constants of the burst RMS and peak level meter
// Holds the beat types of the sample and result channels, the burst summary
// that travels from the front end to the back end, and sizing constants.
// ----------------------------------------------------------------------------
package brpm_pkg;

  // Default burst length limit
  localparam int unsigned MaxSamplesDef = 128;

  // Register reset value and magnitude ceiling
  localparam logic [4:0]  ShiftReset = 5'd14;
  localparam logic [31:0] MagLimit   = 32'd8388608;

  // Burst summary queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Iterative divide and square root lengths
  localparam int unsigned SumW      = 54;
  localparam int unsigned DivSteps  = SumW;
  localparam int unsigned SqrtSteps = SumW / 2;
  localparam int unsigned IterW     = $clog2(DivSteps);

  typedef struct packed {
    logic signed [31:0] raw_sample;
    logic               last_sample;
  } sample_t;

  typedef struct packed {
    logic [23:0]        rms_level;
    logic [23:0]        peak_level;
    logic signed [31:0] first_raw;
  } result_t;

  typedef struct packed {
    logic [SumW-1:0] square_sum;
    logic [7:0]      sample_count;
    logic [23:0]     peak;
    logic [31:0]     first;
  } burst_t;

endpackage

// ===== hdl/block_rms_peak_meter.sv =====
// The last sample beat passes stages A and B into the summary queue; the back end
//   then pops it, divides, takes the square root and registers the result.
// Throughput: one sample beat per cycle while full is low; one burst result at a
//   time from the shared one-bit-a-cycle divide and square root unit; 4 summaries queue.
// Reset: asynchronous, active low; accumulators, queue and result valid flag clear,
//   shift_q returns to 14.
// ----------------------------------------------------------------------------
// block_rms_peak_meter: burst RMS and peak level meter
// Accumulates squared, shifted sample magnitudes of a burst and reports the RMS
// level, the peak magnitude and the first raw sample when the last sample arrives.
// ----------------------------------------------------------------------------
module block_rms_peak_meter #(
  parameter int unsigned MaxSamples = brpm_pkg::MaxSamplesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  brpm_pkg::sample_t sample_i,
  output logic              empty,
  input  logic              pop,
  output brpm_pkg::result_t result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [4:0]        cfg_data_i
);
  import brpm_pkg::*;

  logic [4:0]       shift_q;
  logic             q_push, q_pop, q_empty, q_full;
  logic [QCntW-1:0] q_count;
  burst_t           q_wdata, q_rdata;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= ShiftReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      shift_q <= cfg_data_i;
    end
  end

  brpm_front #(
    .MaxSamples(MaxSamples)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .sample_i (sample_i),
    .shift_i  (shift_q),
    .q_count_i(q_count),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  brpm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty),
    .full_o (q_full),
    .count_o(q_count)
  );

  brpm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_data_i (q_rdata),
    .q_empty_i(q_empty),
    .q_pop_o  (q_pop),
    .result_o (result_o),
    .empty    (empty),
    .pop      (pop)
  );

`ifndef SYNTH
  // Front end never pushes a summary the queue cannot hold
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("summary pushed into a full queue");

  // Back end only pops a summary that is there
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("summary popped from an empty queue");

  // Fill level stays within the queue depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCntW'(QDepth))
    else $error("queue fill level beyond depth");

  // A full queue stalls the sample input
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> full)
    else $error("sample input open while queue is full");
`endif

endmodule

// ===== hdl/brpm_front.sv =====
// ----------------------------------------------------------------------------
// brpm_front: sample front end
// Takes sample beats, forms the shifted and saturated magnitude, squares it
// and accumulates the burst; pushes a burst summary on the last sample.
// ----------------------------------------------------------------------------
module brpm_front #(
  parameter int unsigned MaxSamples = brpm_pkg::MaxSamplesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  brpm_pkg::sample_t        sample_i,
  input  logic [4:0]               shift_i,
  input  logic [brpm_pkg::QCntW-1:0] q_count_i,
  output logic                     q_push_o,
  output brpm_pkg::burst_t         q_data_o
);
  import brpm_pkg::*;

  localparam int unsigned FillW = QCntW + 1;

  logic        accept;
  logic [31:0] fold_w, shifted_w, mag_full;
  logic [23:0] mag;
  logic        take, is_first;

  logic        a_valid_q, a_last_q, a_take_q, a_first_q;
  logic [23:0] a_mag_q;
  logic [31:0] a_word_q;
  logic [7:0]  cnt_q, cnt_d;

  logic        b_valid_q, b_last_q, b_take_q, b_first_q;
  logic [23:0] b_mag_q;
  logic [31:0] b_word_q;
  logic [47:0] b_sq_q;

  logic [SumW-1:0] sum_q, sum_nxt;
  logic [23:0]     peak_q, peak_nxt;
  logic [7:0]      count_q, count_nxt;
  logic [31:0]     first_q, first_nxt;
  logic [FillW-1:0] fill;

  // Hold off new samples while the queue could not take every burst in flight
  assign fill = FillW'(q_count_i) + FillW'(a_valid_q & a_last_q)
              + FillW'(b_valid_q & b_last_q);
  assign full   = fill >= FillW'(QDepth);
  assign accept = push && !full;

  // Shift and take the magnitude, saturate at the ceiling
  always_comb begin
    fold_w    = sample_i.raw_sample[31] ? ~sample_i.raw_sample : sample_i.raw_sample;
    shifted_w = fold_w >> shift_i;
    mag_full  = sample_i.raw_sample[31] ? shifted_w + 32'd1 : shifted_w;
    mag       = (mag_full > MagLimit) ? MagLimit[23:0] : mag_full[23:0];
    take      = cnt_q < 8'(MaxSamples);
    is_first  = cnt_q == 8'd0;
  end

  // Count accepted samples of the current burst, up to MaxSamples
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (sample_i.last_sample) begin
        cnt_d = 8'd0;
      end else if (take) begin
        cnt_d = cnt_q + 8'd1;
      end
    end
  end

  // Stage A: classified sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      cnt_q     <= 8'd0;
    end else begin
      a_valid_q <= accept;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_last_q  <= sample_i.last_sample;
      a_take_q  <= take;
      a_first_q <= is_first;
      a_mag_q   <= mag;
      a_word_q  <= sample_i.raw_sample;
    end
  end

  // Stage B: square
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      b_last_q  <= a_last_q;
      b_take_q  <= a_take_q;
      b_first_q <= a_first_q;
      b_mag_q   <= a_mag_q;
      b_word_q  <= a_word_q;
      b_sq_q    <= 48'(a_mag_q) * 48'(a_mag_q);
    end
  end

  // Stage C: accumulate
  always_comb begin
    sum_nxt   = sum_q;
    peak_nxt  = peak_q;
    count_nxt = count_q;
    first_nxt = first_q;
    if (b_valid_q && b_take_q) begin
      sum_nxt   = sum_q + SumW'(b_sq_q);
      peak_nxt  = (b_mag_q > peak_q) ? b_mag_q : peak_q;
      count_nxt = count_q + 8'd1;
      if (b_first_q) begin
        first_nxt = b_word_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      peak_q  <= '0;
      count_q <= '0;
      first_q <= '0;
    end else if (b_valid_q && b_last_q) begin
      sum_q   <= '0;
      peak_q  <= '0;
      count_q <= '0;
      first_q <= '0;
    end else begin
      sum_q   <= sum_nxt;
      peak_q  <= peak_nxt;
      count_q <= count_nxt;
      first_q <= first_nxt;
    end
  end

  // Hand the finished burst to the queue
  assign q_push_o              = b_valid_q && b_last_q;
  assign q_data_o.square_sum   = sum_nxt;
  assign q_data_o.sample_count = count_nxt;
  assign q_data_o.peak         = peak_nxt;
  assign q_data_o.first        = first_nxt;

endmodule

// ===== hdl/brpm_queue.sv =====
// ----------------------------------------------------------------------------
// brpm_queue: burst summary queue
// Short first-in first-out store that decouples the sample front end from
// the divide and square root back end.
// ----------------------------------------------------------------------------
module brpm_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  brpm_pkg::burst_t           data_i,
  input  logic                       pop_i,
  output brpm_pkg::burst_t           data_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [brpm_pkg::QCntW-1:0] count_o
);
  import brpm_pkg::*;

  burst_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Store the incoming summary
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = count_q == '0;
  assign full_o  = count_q == QCntW'(QDepth);
  assign count_o = count_q;

endmodule

// ===== hdl/brpm_back.sv =====
// ----------------------------------------------------------------------------
// brpm_back: RMS back end
// Divides the sum of squares by the sample count one quotient bit a cycle,
// takes the integer square root one result bit a cycle and holds the result.
// ----------------------------------------------------------------------------
module brpm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brpm_pkg::burst_t    q_data_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  output brpm_pkg::result_t   result_o,
  output logic                empty,
  input  logic                pop
);
  import brpm_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StSqrt = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]      st_q, st_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic [SumW-1:0] val_q, val_d;
  logic [SumW-1:0] res_q, res_d;
  logic [SumW-1:0] bit_q, bit_d;
  logic [7:0]      rem_q, rem_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [23:0]     peak_q, peak_d;
  logic [31:0]     first_q, first_d;
  logic            out_valid_q;
  result_t         out_q;
  logic            load_out;

  logic [8:0]      rem_sh;
  logic            ge;
  logic [SumW-1:0] trial;

  // Sequence the divide, then the square root
  always_comb begin
    st_d     = st_q;
    iter_d   = iter_q;
    val_d    = val_q;
    res_d    = res_q;
    bit_d    = bit_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    peak_d   = peak_q;
    first_d  = first_q;
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    rem_sh   = {rem_q, val_q[SumW-1]};
    ge       = rem_sh >= {1'b0, cnt_q};
    trial    = res_q + bit_q;
    unique case (st_q)
      StIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          val_d   = q_data_i.square_sum;
          cnt_d   = q_data_i.sample_count;
          peak_d  = q_data_i.peak;
          first_d = q_data_i.first;
          rem_d   = '0;
          res_d   = '0;
          iter_d  = '0;
          // An empty burst gives a zero level
          st_d    = (q_data_i.sample_count == 8'd0) ? StOut : StDiv;
        end
      end
      StDiv: begin
        rem_d  = ge ? 8'(rem_sh - {1'b0, cnt_q}) : rem_sh[7:0];
        val_d  = {val_q[SumW-2:0], ge};
        iter_d = iter_q + IterW'(1);
        if (iter_q == IterW'(DivSteps - 1)) begin
          st_d   = StSqrt;
          iter_d = '0;
          res_d  = '0;
          bit_d  = SumW'(1) << (2 * (SqrtSteps - 1));
        end
      end
      StSqrt: begin
        if (val_q >= trial) begin
          val_d = val_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d  = bit_q >> 2;
        iter_d = iter_q + IterW'(1);
        if (iter_q == IterW'(SqrtSteps - 1)) begin
          st_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || pop) begin
          load_out = 1'b1;
          st_d     = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q  <= iter_d;
    val_q   <= val_d;
    res_q   <= res_d;
    bit_q   <= bit_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    peak_q  <= peak_d;
    first_q <= first_d;
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.rms_level  <= res_q[23:0];
      out_q.peak_level <= peak_q;
      out_q.first_raw  <= first_q;
    end
  end

  assign result_o = out_q;
  assign empty    = !out_valid_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the burst RMS and peak level meter
// A short table of hand-picked bursts is followed by random bursts under
// several shift settings. Every accepted sample is folded into a local
// predictor, and every result beat is compared with the oldest level due.
// Both sides idle in random bursts, and the receiver holds off once so that
// the block fills up.
// ----------------------------------------------------------------------------
module tb;
  import brpm_pkg::*;

  localparam int unsigned BurstCap    = MaxSamplesDef;
  localparam int          DrainCycles = 100;
  localparam int          HoldCycles  = 800;
  localparam int          QuietLimit  = 5000;
  localparam int          PhaseBudget = 140;

  typedef enum logic {ROW_SHIFT, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [4:0] shift;
    sample_t    smp;
    bit         typed;
    result_t    want;
  } row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  sample_t    sample_i;
  logic       empty;
  logic       pop;
  result_t    result_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i;

  // Predictor state
  logic [4:0]  shift_reg;
  logic [53:0] burst_sum;
  logic [23:0] burst_peak;
  logic [7:0]  burst_count;
  logic [31:0] burst_first;

  result_t levels_due[$];
  row_t    rows[$];
  int      mismatch_count;
  int      quiet_cycles;
  bit      idle_en;
  bit      hold_req;

  block_rms_peak_meter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .sample_i    (sample_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shift right arithmetically, take the magnitude and clamp it
  function automatic logic [23:0] shifted_mag(logic [31:0] w, logic [4:0] sh);
    logic [31:0] m;
    if (w[31]) begin
      m = ((~w) >> sh) + 32'd1;
    end else begin
      m = w >> sh;
    end
    if (m > MagLimit) begin
      m = MagLimit;
    end
    return m[23:0];
  endfunction

  // Floor square root, one result bit at a time from the top
  function automatic logic [23:0] floor_sqrt(logic [53:0] v);
    logic [27:0] root;
    logic [27:0] cand;
    root = '0;
    for (int b = 27; b >= 0; b--) begin
      cand = root | (28'd1 << b);
      if (56'(cand) * 56'(cand) <= 56'(v)) begin
        root = cand;
      end
    end
    return root[23:0];
  endfunction

  // Fold one sample into the burst; return 1 with the levels on the last one
  function automatic bit fold_sample(input sample_t s, output result_t lv);
    logic [23:0] mag;
    lv = '0;
    if (burst_count < BurstCap) begin
      mag = shifted_mag(s.raw_sample, shift_reg);
      if (burst_count == 8'd0) begin
        burst_first = s.raw_sample;
      end
      burst_sum = burst_sum + 54'(mag) * 54'(mag);
      if (mag > burst_peak) begin
        burst_peak = mag;
      end
      burst_count = burst_count + 8'd1;
    end
    if (!s.last_sample) begin
      return 1'b0;
    end
    if (burst_count != 8'd0) begin
      lv.rms_level = floor_sqrt(burst_sum / 54'(burst_count));
    end
    lv.peak_level = burst_peak;
    lv.first_raw  = burst_first;
    burst_sum   = '0;
    burst_peak  = '0;
    burst_count = '0;
    burst_first = '0;
    return 1'b1;
  endfunction

  // Offer one sample beat, idling first now and then
  task automatic send_sample(sample_t s, bit typed, result_t want);
    result_t lv;
    int      gap;
    if (idle_en && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    @(negedge clk_i);
    push     <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (full);
    if (fold_sample(s, lv)) begin
      levels_due.push_back(typed ? want : lv);
    end
  endtask

  // Write the shift register once the block has gone quiet
  task automatic write_shift(logic [4:0] v);
    @(negedge clk_i);
    push <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    shift_reg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_shift_row(logic [4:0] v);
    row_t r;
    r       = '{kind: ROW_SHIFT, default: '0};
    r.shift = v;
    rows.push_back(r);
  endtask

  task automatic add_sample_row(logic [31:0] raw, bit last);
    row_t r;
    r                 = '{kind: ROW_SAMPLE, default: '0};
    r.smp.raw_sample  = raw;
    r.smp.last_sample = last;
    rows.push_back(r);
  endtask

  // Single-sample burst whose levels are known by hand
  task automatic add_checked_row(logic [31:0] raw, logic [23:0] rms, logic [23:0] peak);
    row_t r;
    r                 = '{kind: ROW_SAMPLE, default: '0};
    r.smp.raw_sample  = raw;
    r.smp.last_sample = 1'b1;
    r.typed           = 1'b1;
    r.want.rms_level  = rms;
    r.want.peak_level = peak;
    r.want.first_raw  = raw;
    rows.push_back(r);
  endtask

  // Pick a raw word: extremes, quiet values or anything at all
  function automatic logic [31:0] pick_raw();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'(int'($urandom_range(0, 2047)) - 1024);
      default: return $urandom();
    endcase
  endfunction

  // Send random bursts until the budget is spent; every burst ends on a last beat
  task automatic run_bursts(int budget);
    int      sent;
    int      len;
    sample_t s;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 19))
        0:       len = 1;
        1:       len = $urandom_range(126, 134);
        default: len = $urandom_range(2, 24);
      endcase
      for (int k = 0; k < len; k++) begin
        s.raw_sample  = pick_raw();
        s.last_sample = (k == len - 1);
        send_sample(s, 1'b0, '0);
      end
      sent += len;
    end
  endtask

  // Send single-sample bursts, each one a summary of its own
  task automatic run_singles(int n);
    sample_t s;
    for (int k = 0; k < n; k++) begin
      s.raw_sample  = pick_raw();
      s.last_sample = 1'b1;
      send_sample(s, 1'b0, '0);
    end
  endtask

  // Result side: pop with random stalls, and one long hold-off on request
  initial begin : result_drain
    int stall_left;
    stall_left = 0;
    pop        = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        pop <= 1'b1;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Check each result beat against the oldest levels due
  always @(posedge clk_i) begin : result_check
    result_t due;
    if (rst_ni && pop && !empty) begin
      if (levels_due.size() == 0) begin
        $display("%0t: result beat with nothing due: rms %0d peak %0d first %0d",
                 $time, result_o.rms_level, result_o.peak_level, result_o.first_raw);
        mismatch_count++;
      end else begin
        due = levels_due.pop_front();
        if (result_o.rms_level !== due.rms_level) begin
          $display("%0t: rms_level expected %0d, got %0d",
                   $time, due.rms_level, result_o.rms_level);
          mismatch_count++;
        end
        if (result_o.peak_level !== due.peak_level) begin
          $display("%0t: peak_level expected %0d, got %0d",
                   $time, due.peak_level, result_o.peak_level);
          mismatch_count++;
        end
        if (result_o.first_raw !== due.first_raw) begin
          $display("%0t: first_raw expected %0d, got %0d",
                   $time, due.first_raw, result_o.first_raw);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on any channel
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: watchdog expired, %0d levels still due", $time, levels_due.size());
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main_seq
    logic [4:0] phase_shift [8];
    rst_ni         = 1'b0;
    push           = 1'b0;
    sample_i       = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    idle_en        = 1'b1;
    hold_req       = 1'b0;
    shift_reg      = ShiftReset;
    burst_sum      = '0;
    burst_peak     = '0;
    burst_count    = '0;
    burst_first    = '0;

    // Hand-picked bursts, starting at the reset shift
    add_checked_row(32'h0000_0000, 24'd0, 24'd0);
    add_checked_row(32'h7FFF_FFFF, 24'd131071, 24'd131071);
    add_checked_row(32'h8000_0000, 24'd131072, 24'd131072);
    add_checked_row(32'hFFFF_FFFF, 24'd1, 24'd1);
    add_sample_row(32'h4000_0000, 1'b0);
    add_sample_row(32'hC000_0000, 1'b0);
    add_sample_row(32'h0000_1234, 1'b1);
    // No shift at all: loud samples clamp
    add_shift_row(5'd0);
    add_checked_row(32'h7FFF_FFFF, 24'd8388608, 24'd8388608);
    add_checked_row(32'h8000_0000, 24'd8388608, 24'd8388608);
    add_sample_row(32'h0080_0001, 1'b0);
    add_sample_row(32'h007F_FFFF, 1'b1);
    // Widest shift: only the sign survives
    add_shift_row(5'd31);
    add_checked_row(32'h7FFF_FFFF, 24'd0, 24'd0);
    add_checked_row(32'h8000_0000, 24'd1, 24'd1);
    add_checked_row(32'hFFFF_FFFF, 24'd1, 24'd1);
    add_shift_row(5'd8);
    add_sample_row(32'h5555_5555, 1'b0);
    add_sample_row(32'hAAAA_AAAA, 1'b1);
    add_shift_row(5'd16);
    add_sample_row(32'h1234_5678, 1'b0);
    add_sample_row(32'h89AB_CDEF, 1'b0);
    add_sample_row(32'h0000_0000, 1'b1);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the table
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_SHIFT) begin
        write_shift(rows[i].shift);
      end else begin
        send_sample(rows[i].smp, rows[i].typed, rows[i].want);
      end
    end

    // Random bursts under a range of shifts, the extremes among the first four
    phase_shift[0] = 5'd8;
    phase_shift[1] = 5'd16;
    phase_shift[2] = 5'd0;
    phase_shift[3] = 5'd31;
    phase_shift[4] = 5'($urandom_range(0, 31));
    phase_shift[5] = 5'($urandom_range(8, 16));
    phase_shift[6] = 5'($urandom_range(0, 31));
    phase_shift[7] = ShiftReset;
    for (int p = 0; p < 8; p++) begin
      write_shift(phase_shift[p]);
      if (p == 7) begin
        idle_en = 1'b0;
      end
      run_bursts(PhaseBudget);
      // Hold the receiver off while single-sample bursts pile up
      if (p == 2) begin
        hold_req = 1'b1;
        run_singles(40);
      end
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
